@@ src/aip_pkg.sv @@
package aip_pkg;

	localparam int CharW    = 8;
	localparam int ValueW   = 64;
	localparam int HalfW    = ValueW / 2;
	localparam int ModeW    = 3;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 3;

	localparam logic [ModeW-1:0] MODE_DEC_U  = 3'd0;
	localparam logic [ModeW-1:0] MODE_DEC_S  = 3'd1;
	localparam logic [ModeW-1:0] MODE_HEX    = 3'd2;
	localparam logic [ModeW-1:0] MODE_AUTO_U = 3'd3;
	localparam logic [ModeW-1:0] MODE_AUTO_S = 3'd4;

	localparam logic [CfgIdxW-1:0] REG_PARSE_MODE  = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_WIDE_RESULT = 1'b1;

	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;
	localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
	localparam logic [CharW-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_TAB   = 8'h09;
	localparam logic [CharW-1:0] CH_CR    = 8'h0d;
	localparam logic [CharW-1:0] CH_LO_X  = 8'h78;
	localparam logic [CharW-1:0] CH_UP_X  = 8'h58;
	localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
	localparam logic [CharW-1:0] CH_LO_F  = 8'h66;
	localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
	localparam logic [CharW-1:0] CH_UP_F  = 8'h46;

	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_ZERO  = 5'b00010,
		PH_HEX   = 5'b00100,
		PH_DEC   = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	function automatic logic is_dec(input logic [CharW-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_white(input logic [CharW-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_sign(input logic [CharW-1:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	function automatic logic is_hex_pref(input logic [CharW-1:0] c);
		return (c == CH_LO_X) || (c == CH_UP_X);
	endfunction

	// bit 4 set when c is a hex digit, low bits give its value
	function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
		logic [CharW-1:0] d;
		d = '0;
		if (is_dec(c)) begin
			d = c - CH_ZERO;
			return {1'b1, d[3:0]};
		end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
			d = c - CH_LO_A + 8'd10;
			return {1'b1, d[3:0]};
		end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
			d = c - CH_UP_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'b0;
	endfunction

endpackage

@@ src/aip_if.sv @@
interface aip_in_if;
	logic                       valid;
	logic                       ready;
	logic [aip_pkg::CharW-1:0]  char_code;
	logic                       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface aip_out_if;
	logic                       valid;
	logic                       ready;
	logic [aip_pkg::ValueW-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface aip_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [aip_pkg::CfgIdxW-1:0]  index;
	logic [aip_pkg::CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/ascii_integer_parser_top.sv @@
// Parses a decimal or hex number string fed one character per beat on din, with is_last on
// the final character, and returns one 64-bit value on dout per string (zero-extended low
// 32 bits when wide_result is 0). A character can be accepted every cycle unless dout
// stalls a last one; the per-string state is updated by one shift-add of the accumulator
// in the cycle after a character is registered; a string's value goes via the s2 register
// to dout, with the final negate in a stage of its own. cfg registers (0 parse_mode, 1
// wide_result) may only be written while no string is in progress or in flight.
module ascii_integer_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	aip_in_if.sink     din,
	aip_out_if.source  dout,
	aip_cfg_if.sink    cfg
);

	logic [aip_pkg::ModeW-1:0]  mode_q;
	logic                       wide_q;

	logic                       s1_valid_q;
	logic [aip_pkg::CharW-1:0]  char_s1;
	logic                       last_s1;

	aip_pkg::phase_t            phase_q;
	logic [aip_pkg::ValueW-1:0] acc_q;
	logic                       neg_q;

	logic                       s2_valid_q;
	logic [aip_pkg::ValueW-1:0] acc_s2;
	logic                       neg_s2;
	logic                       wide_s2;

	logic                       out_valid_q;
	logic [aip_pkg::ValueW-1:0] value_q;

	aip_pkg::phase_t            phase_n;
	logic [aip_pkg::ValueW-1:0] acc_n;
	logic                       neg_n;
	logic [aip_pkg::ModeW-1:0]  mode_eff;
	logic                       signed_form;
	logic [4:0]                 hex_d;
	logic [aip_pkg::ValueW-1:0] dec_d;
	logic [aip_pkg::ValueW-1:0] neg_val;

	logic out_free, s2_adv, s2_free, s1_fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= aip_pkg::MODE_AUTO_S;
			wide_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				aip_pkg::REG_PARSE_MODE:  mode_q <= cfg.data;
				aip_pkg::REG_WIDE_RESULT: wide_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// handshake chain
	assign out_free  = !out_valid_q || dout.ready;
	assign s2_adv    = s2_valid_q && out_free;
	assign s2_free   = !s2_valid_q || out_free;
	assign s1_fire   = s1_valid_q && (!last_s1 || s2_free);
	assign din.ready = !s1_valid_q || s1_fire;

	// next parse state for the registered character
	always_comb begin
		mode_eff    = (mode_q > aip_pkg::MODE_AUTO_S) ? aip_pkg::MODE_AUTO_S : mode_q;
		signed_form = (mode_eff == aip_pkg::MODE_DEC_S) || (mode_eff == aip_pkg::MODE_HEX) ||
			(mode_eff == aip_pkg::MODE_AUTO_S);
		hex_d   = aip_pkg::hex_digit(char_s1);
		dec_d   = {{(aip_pkg::ValueW-4){1'b0}}, char_s1[3:0]};
		phase_n = phase_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		unique case (phase_q)
			aip_pkg::PH_START: begin
				if (signed_form && (aip_pkg::is_sign(char_s1) || aip_pkg::is_white(char_s1))) begin
					if (char_s1 == aip_pkg::CH_MINUS) neg_n = !neg_q;
				end else if ((mode_eff == aip_pkg::MODE_DEC_U) ||
						(mode_eff == aip_pkg::MODE_DEC_S)) begin
					if (aip_pkg::is_dec(char_s1)) begin
						acc_n   = dec_d;
						phase_n = aip_pkg::PH_DEC;
					end else begin
						phase_n = aip_pkg::PH_DONE;
					end
				end else if (char_s1 == aip_pkg::CH_ZERO) begin
					phase_n = aip_pkg::PH_ZERO;
				end else if ((mode_eff != aip_pkg::MODE_HEX) && aip_pkg::is_dec(char_s1)) begin
					acc_n   = dec_d;
					phase_n = aip_pkg::PH_DEC;
				end else begin
					phase_n = aip_pkg::PH_DONE;
				end
			end
			aip_pkg::PH_ZERO: begin
				phase_n = aip_pkg::is_hex_pref(char_s1) ? aip_pkg::PH_HEX : aip_pkg::PH_DONE;
			end
			aip_pkg::PH_HEX: begin
				if (hex_d[4]) acc_n = {acc_q[aip_pkg::ValueW-5:0], hex_d[3:0]};
				else phase_n = aip_pkg::PH_DONE;
			end
			aip_pkg::PH_DEC: begin
				if (aip_pkg::is_dec(char_s1)) acc_n = (acc_q << 3) + (acc_q << 1) + dec_d;
				else phase_n = aip_pkg::PH_DONE;
			end
			aip_pkg::PH_DONE: phase_n = aip_pkg::PH_DONE;
			default: phase_n = aip_pkg::PH_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (din.valid && din.ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			char_s1 <= din.char_code;
			last_s1 <= din.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= aip_pkg::PH_START;
			acc_q   <= '0;
			neg_q   <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				phase_q <= aip_pkg::PH_START;
				acc_q   <= '0;
				neg_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			s2_valid_q <= 1'b1;
		end else if (s2_adv) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			acc_s2  <= acc_n;
			neg_s2  <= neg_n;
			wide_s2 <= wide_q;
		end
	end

	// sign and width of the result
	always_comb begin
		neg_val = neg_s2 ? ('0 - acc_s2) : acc_s2;
		if (!wide_s2) neg_val = {{(aip_pkg::ValueW-aip_pkg::HalfW){1'b0}},
			neg_val[aip_pkg::HalfW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) value_q <= neg_val;
	end

	assign dout.valid = out_valid_q;
	assign dout.value = value_q;

endmodule
